// ===== rtl/core/mac_learning_switch_table_assert.svh =====
// Assertion macros shared by the MAC learning table RTL.
// Depends on nothing; included by the top level only.
`ifndef MAC_LEARNING_SWITCH_TABLE_ASSERT_SVH
`define MAC_LEARNING_SWITCH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLST_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLST_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mlst_pkg.sv =====
// Shared types and constants of the MAC learning table.
// No dependencies; used by mlst_ctrl, mlst_dp and the top level.
`default_nettype none

package mlst_pkg;

    localparam int unsigned MAC_W  = 48;
    localparam int unsigned PORT_W = 4;
    localparam int unsigned STAT_W = 2;

    // Default table depth.
    localparam int unsigned TABLE_ENTRIES_DEF = 64;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    // Learn status codes.
    localparam logic [STAT_W-1:0] LS_SAME  = 2'd0;
    localparam logic [STAT_W-1:0] LS_ADDED = 2'd1;
    localparam logic [STAT_W-1:0] LS_MOVED = 2'd2;
    localparam logic [STAT_W-1:0] LS_FULL  = 2'd3;

    // One received frame header.
    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] recv_port;
    } hdr_t;

    // One forwarding decision.
    typedef struct packed {
        logic              flood;
        logic [PORT_W-1:0] out_port;
        logic [STAT_W-1:0] learn_status;
    } fwd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic resolve;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tbl_empty;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mlst_ctrl.sv =====
// Sequencer of the MAC learning table: accept, scan, drain, resolve.
// Depends on mlst_pkg for the command and status structs.
`default_nettype none

module mlst_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          hdr_valid,
    output logic               hdr_stall,
    input  wire mlst_pkg::sts_t sts,
    output mlst_pkg::cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_RESOLVE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.resolve = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (hdr_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.tbl_empty ? ST_RESOLVE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last entry read is compared in this cycle.
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (sts.out_free)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new header is taken only while idle.
    assign hdr_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/mlst_dp.sv =====
// Datapath of the MAC learning table: table memory, fill count, scan
// compare, learn and forward decision, and output register.
// Depends on mlst_pkg for payload, command and status types.
`default_nettype none

module mlst_dp #(
    parameter int unsigned TABLE_ENTRIES = mlst_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mlst_pkg::hdr_t hdr,
    input  wire mlst_pkg::cmd_t cmd,
    output mlst_pkg::sts_t     sts,
    output logic               fwd_valid,
    input  wire logic          fwd_stall,
    output mlst_pkg::fwd_t     fwd
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned ENT_W = mlst_pkg::MAC_W + mlst_pkg::PORT_W;

    // Table memory: one entry is {mac, port}.
    logic [ENT_W-1:0] tbl_mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] rd_data_reg;

    // Captured header.
    mlst_pkg::hdr_t hdr_reg;

    // Scan pointer and compare pipeline.
    logic [CNT_W-1:0] scan_idx_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    // Match results.
    logic                        src_hit_reg;
    logic [IDX_W-1:0]            src_idx_reg;
    logic [mlst_pkg::PORT_W-1:0] src_port_reg;
    logic                        dst_hit_reg;
    logic [mlst_pkg::PORT_W-1:0] dst_port_reg;

    // Fill count: entries are only ever appended, so slot i is valid when
    // i is below the count and the next free slot is the count itself.
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    mlst_pkg::fwd_t   out_item_reg;

    logic [mlst_pkg::MAC_W-1:0]  rd_mac;
    logic [mlst_pkg::PORT_W-1:0] rd_port;
    logic                        src_match;
    logic                        dst_match;
    logic                        tbl_full;
    logic [mlst_pkg::STAT_W-1:0] learn_status;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    mlst_pkg::fwd_t              result;

    assign rd_mac  = rd_data_reg[ENT_W-1:mlst_pkg::PORT_W];
    assign rd_port = rd_data_reg[mlst_pkg::PORT_W-1:0];

    // Compare the entry read in the previous cycle against both addresses.
    assign src_match = cmp_vld_reg && (rd_mac == hdr_reg.src_mac);
    assign dst_match = cmp_vld_reg && (rd_mac == hdr_reg.dst_mac);

    assign tbl_full = (fill_count_reg == CNT_W'(TABLE_ENTRIES));

    // Learn decision.
    always_comb
    begin
        if (src_hit_reg)
        begin
            learn_status = (src_port_reg == hdr_reg.recv_port) ?
                           mlst_pkg::LS_SAME : mlst_pkg::LS_MOVED;
        end
        else
        begin
            learn_status = tbl_full ? mlst_pkg::LS_FULL : mlst_pkg::LS_ADDED;
        end
    end

    assign wr_en   = cmd.resolve && (learn_status != mlst_pkg::LS_SAME) &&
                     (learn_status != mlst_pkg::LS_FULL);
    assign wr_addr = src_hit_reg ? src_idx_reg : fill_count_reg[IDX_W-1:0];

    // Forward decision. Learning comes first, so a destination equal to the
    // source hits on the arrival port unless the source could not be stored.
    always_comb
    begin
        result.learn_status = learn_status;
        result.out_port     = hdr_reg.recv_port;
        result.flood        = 1'b1;
        if (hdr_reg.dst_mac == mlst_pkg::BCAST_MAC)
        begin
            result.flood = 1'b1;
        end
        else if (hdr_reg.dst_mac == hdr_reg.src_mac)
        begin
            result.flood = (learn_status == mlst_pkg::LS_FULL);
        end
        else if (dst_hit_reg)
        begin
            result.flood    = 1'b0;
            result.out_port = dst_port_reg;
        end
        else
        begin
            result.flood = 1'b1;
        end
    end

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= {hdr_reg.src_mac, hdr_reg.recv_port};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= tbl_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hdr_reg <= hdr;
        end
        if (cmd.rd_en)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (src_match)
        begin
            src_idx_reg  <= cmp_idx_reg;
            src_port_reg <= rd_port;
        end
        if (dst_match)
        begin
            dst_port_reg <= rd_port;
        end
        if (cmd.resolve)
        begin
            out_item_reg <= result;
        end
    end

    // Next fill count and output valid.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (wr_en && !src_hit_reg)
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        out_valid_next = out_valid_reg && fwd_stall;
        if (cmd.resolve)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            src_hit_reg    <= 1'b0;
            dst_hit_reg    <= 1'b0;
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmp_vld_reg    <= cmd.rd_en;
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
                src_hit_reg  <= 1'b0;
                dst_hit_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.rd_en)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (src_match)
                begin
                    src_hit_reg <= 1'b1;
                end
                if (dst_match)
                begin
                    dst_hit_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.tbl_empty = (fill_count_reg == '0);
    assign sts.scan_last = ((scan_idx_reg + CNT_W'(1)) == fill_count_reg);
    assign sts.out_free  = !out_valid_reg || !fwd_stall;

    assign fwd_valid = out_valid_reg;
    assign fwd       = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mac_learning_switch_table.sv =====
// MAC learning table of a transparent Ethernet bridge. Each header item
// (source, destination, arrival port) first teaches the table its source
// address: a new address is added in the next free slot, a known one on a
// different port is moved, and when the table is full a new address is not
// stored and learn_status reports it. The destination is then looked up:
// broadcast or unknown addresses flood (out_port echoes the arrival port),
// known ones go unicast to their stored port. Entries never age out. An
// item is accepted, every learned entry is read once through the single
// read port of the table memory, the last one read gets a final compare,
// and the decision commits once the output register is free; an empty
// table skips the scan and the final compare. The output register lets the
// next header be accepted while a decision waits to be taken.
// Depends on mlst_pkg, mlst_ctrl, mlst_dp and the assertion macro header.
`default_nettype none

`include "mac_learning_switch_table_assert.svh"

module mac_learning_switch_table #(
    parameter int unsigned TABLE_ENTRIES = mlst_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          hdr_valid,
    output logic               hdr_stall,
    input  wire mlst_pkg::hdr_t hdr,
    output logic               fwd_valid,
    input  wire logic          fwd_stall,
    output mlst_pkg::fwd_t     fwd
);

    mlst_pkg::cmd_t cmd;
    mlst_pkg::sts_t sts;
    logic           hdr_accept;

    // Sequencer.
    mlst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table and decision logic.
    mlst_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .cmd       (cmd),
        .sts       (sts),
        .fwd_valid (fwd_valid),
        .fwd_stall (fwd_stall),
        .fwd       (fwd)
    );

    assign hdr_accept = hdr_valid && !hdr_stall;

    // An accepted item blocks the input until it has been resolved.
    `MLST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, hdr_accept, hdr_stall, "no stall after accept")

    // A result only commits when the output register can take it.
    `MLST_ASSERT_NOW(a_resolve_out_free, clk, rst_n, cmd.resolve, sts.out_free, "resolve while full")

    // A new result appears only right after a commit.
    `MLST_ASSERT_NOW(a_out_from_resolve, clk, rst_n, $rose(fwd_valid), $past(cmd.resolve), "no commit")

    // Table reads only happen while an item is in progress.
    `MLST_ASSERT_NOW(a_read_when_busy, clk, rst_n, cmd.rd_en, hdr_stall && !cmd.capture, "stray read")

endmodule

`default_nettype wire
